[rtl/stt_pkg.sv]
// Shared types, character classes and lookup tables for the source text tokenizer.
// No dependencies; every rtl file takes names from here by scoped reference.
package stt_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } stt_in_t;

  typedef struct packed {
    logic [6:0]  token_kind;
    logic [23:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
  } stt_out_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] kind;
  } op_hit_t;

  localparam logic [6:0] KIND_IDENT    = 7'd0;
  localparam logic [6:0] KIND_OP0      = 7'd23;
  localparam logic [6:0] KIND_TCOMMENT = 7'd72;
  localparam logic [6:0] KIND_UNTERM   = 7'd73;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Operator table places that need naming outside the lookup functions
  localparam int OP_SHL_EQ = 32;
  localparam int OP_SHL    = 33;
  localparam int OP_SHR_EQ = 34;
  localparam int OP_SHR    = 35;

  localparam int KW_COUNT = 22;
  localparam int KW_CHARS = 16;

  // The one keyword that fills the whole buffer
  localparam logic [KW_CHARS*8-1:0] KW_LONG_CAST = {"reinterpret", "_cast"};

  // Keyword text, right aligned: last character in the low byte
  localparam logic [KW_CHARS*8-1:0] KW_STR [KW_COUNT] = '{
    "for", "in", "where", "while", "do", "namespace", "var", "mut",
    "match", "enum", "struct", "use", "break", "trait", "continue",
    "extern", "module", "impl", "public", "protected", "private",
    KW_LONG_CAST
  };

  localparam int KW_LEN [KW_COUNT] = '{
    3, 2, 5, 5, 2, 9, 3, 3, 5, 4, 6, 3, 5, 5, 8, 6, 6, 4, 6, 9, 7, 16
  };

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_letter(c) || (c >= "0" && c <= "9");
  endfunction

  function automatic op_hit_t op_make(input int idx);
    op_hit_t h;
    h.hit  = 1'b1;
    h.kind = KIND_OP0 + 7'(idx);
    return h;
  endfunction

  // Exact one-character operator
  function automatic op_hit_t op1(input logic [7:0] c);
    op_hit_t h;
    h = '0;
    case (c)
      "&": h = op_make(2);
      "=": h = op_make(4);
      "|": h = op_make(7);
      "^": h = op_make(9);
      ",": h = op_make(10);
      ":": h = op_make(11);
      ";": h = op_make(13);
      "/": h = op_make(15);
      ".": h = op_make(18);
      ">": h = op_make(19);
      "-": h = op_make(23);
      "%": h = op_make(24);
      "!": h = op_make(27);
      "+": h = op_make(30);
      "?": h = op_make(31);
      "*": h = op_make(36);
      "~": h = op_make(37);
      "#": h = op_make(39);
      "$": h = op_make(41);
      "@": h = op_make(42);
      "{": h = op_make(43);
      "}": h = op_make(44);
      "(": h = op_make(45);
      ")": h = op_make(46);
      "[": h = op_make(47);
      "]": h = op_make(48);
      default: h = '0;
    endcase
    return h;
  endfunction

  // A longer operator starts with this character
  function automatic logic op1_longer(input logic [7:0] c);
    logic r;
    case (c)
      "&", "=", "|", "^", ":", "/", ".", ">", "-", "%", "!", "+", "<", "*", "#":
        r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Exact two-character operator, first character in the high byte
  function automatic op_hit_t op2(input logic [15:0] pair);
    op_hit_t h;
    h = '0;
    case (pair)
      "&&": h = op_make(0);
      "&=": h = op_make(1);
      "==": h = op_make(3);
      "||": h = op_make(5);
      "|=": h = op_make(6);
      "^=": h = op_make(8);
      "::": h = op_make(12);
      "/=": h = op_make(14);
      ".*": h = op_make(16);
      ".~": h = op_make(17);
      ">=": h = op_make(20);
      "-=": h = op_make(21);
      "--": h = op_make(22);
      "%=": h = op_make(25);
      "!=": h = op_make(26);
      "+=": h = op_make(28);
      "++": h = op_make(29);
      "<<": h = op_make(OP_SHL);
      ">>": h = op_make(OP_SHR);
      "*=": h = op_make(38);
      "##": h = op_make(40);
      default: h = '0;
    endcase
    return h;
  endfunction

  // Keyword kind of the buffered word, identifier when none matches
  function automatic logic [6:0] kw_kind(input logic [KW_CHARS*8-1:0] head,
                                         input logic [5:0] fill);
    logic [6:0] k;
    logic       hit;
    k = KIND_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      hit = (fill == 6'(KW_LEN[i]));
      for (int j = 0; j < KW_CHARS; j++) begin
        if (j < KW_LEN[i]) begin
          hit = hit && (head[8*j +: 8] == KW_STR[i][8*(KW_LEN[i]-1-j) +: 8]);
        end
      end
      if (hit && k == KIND_IDENT) begin
        k = 7'(i + 1);
      end
    end
    return k;
  endfunction

endpackage

[rtl/source_text_tokenizer_unit.sv]
// Top level of the source text tokenizer: scanner state, token forming and result queue.
// Depends on stt_pkg for payload types, character classes and operator/keyword tables.
//
//  channel  ports                        beat
//  in       in_valid in_ready in_data    one source byte, end_of_text marks the last
//  out      out_valid out_ready out_data one token, last_of_run on the byte's final token
//
// One byte is scanned per cycle while in_ready is high; its tokens (zero to three)
// enter a four-deep result queue. in_ready is high while the queue holds at most one
// token, so bytes of one token or none stream at one per cycle; more tokens stall input.
// Synchronous active-low reset empties the queue and returns the scanner to idle at
// position zero. Stalls on out_ready only fill the queue; no token is dropped.
module source_text_tokenizer_unit #(
  parameter int POS_BITS        = 24,
  parameter int MAX_KEYWORD_LEN = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  stt_pkg::stt_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output stt_pkg::stt_out_t out_data
);

  localparam int FILL_W = $clog2(MAX_KEYWORD_LEN + 2);
  localparam int IDX_W  = $clog2(MAX_KEYWORD_LEN);

  typedef enum logic [2:0] {
    M_IDLE, M_WORD, M_OP, M_LSTART, M_LBODY, M_BSTART, M_BBODY
  } mode_t;

  mode_t                mode_r, mode_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  logic [POS_BITS-1:0]  begin_r, begin_nxt;
  logic [POS_BITS-1:0]  lastns_r, lastns_nxt;
  logic [7:0]           buf_r [MAX_KEYWORD_LEN];
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [15:0]          pend_r, pend_nxt;
  logic                 tflag_r, tflag_nxt;
  logic                 star_r, star_nxt;

  logic                 buf_we;
  logic [IDX_W-1:0]     buf_widx;
  logic [7:0]           buf_wdata;

  stt_pkg::stt_out_t    res [3];
  logic [1:0]           res_cnt;

  stt_pkg::stt_out_t    q_r [4];
  logic [1:0]           wr_r, rd_r;
  logic [2:0]           cnt_r;

  logic                 in_fire, out_fire;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = (cnt_r <= 3'd1);
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = q_r[rd_r];

  function automatic stt_pkg::stt_out_t mk_tok(input logic [6:0] kind,
                                               input logic [POS_BITS-1:0] s,
                                               input logic [POS_BITS-1:0] e);
    stt_pkg::stt_out_t t;
    logic [POS_BITS-1:0]    diff;
    logic [POS_BITS+15:0]   dx;
    diff = e - s;
    dx   = (POS_BITS + 16)'(diff);
    t.token_kind   = kind;
    t.token_start  = 24'(s);
    t.token_length = (dx > (POS_BITS + 16)'(65535)) ? 16'hFFFF : 16'(dx);
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  always_comb begin
    logic [7:0]                      c;
    logic [POS_BITS-1:0]             p;
    logic [POS_BITS-1:0]             body;
    logic                            go_idle;
    logic                            two;
    logic [7:0]                      b0;
    stt_pkg::op_hit_t                h;
    logic [stt_pkg::KW_CHARS*8-1:0]  head, head_nxt;

    c        = in_data.char_code;
    p        = pos_r;
    go_idle  = 1'b0;
    b0       = pend_r[7:0];
    two      = (pend_r[15:8] != 8'd0);
    body     = '0;
    h        = '0;
    res      = '{default: '0};
    res_cnt  = 2'd0;
    buf_we   = 1'b0;
    buf_widx = '0;
    buf_wdata = c;

    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    begin_nxt  = begin_r;
    lastns_nxt = lastns_r;
    fill_nxt   = fill_r;
    pend_nxt   = pend_r;
    tflag_nxt  = tflag_r;
    star_nxt   = star_r;

    for (int j = 0; j < stt_pkg::KW_CHARS; j++) begin
      head[8*j +: 8] = buf_r[j];
    end

    case (mode_r)
      M_IDLE: go_idle = 1'b1;
      M_WORD: begin
        if (stt_pkg::is_word_char(c)) begin
          if (fill_r < FILL_W'(MAX_KEYWORD_LEN)) begin
            buf_we   = 1'b1;
            buf_widx = fill_r[IDX_W-1:0];
            fill_nxt = fill_r + 1'b1;
          end else begin
            fill_nxt = FILL_W'(MAX_KEYWORD_LEN + 1);
          end
        end else begin
          res[res_cnt] = mk_tok(stt_pkg::kw_kind(head, 6'(fill_r)), begin_r, p);
          res_cnt = res_cnt + 1'b1;
          mode_nxt = M_IDLE;
          go_idle = 1'b1;
        end
      end
      M_OP: begin
        if (!two && b0 == "/" && (c == "/" || c == "*")) begin
          mode_nxt = (c == "/") ? M_LSTART : M_BSTART;
          pend_nxt = '0;
        end else if (!two) begin
          h = stt_pkg::op2({b0, c});
          if (h.hit) begin
            if ((b0 == "<" || b0 == ">") && c == b0) begin
              pend_nxt[15:8] = c;
            end else begin
              res[res_cnt] = mk_tok(h.kind, begin_r, p + 1'b1);
              res_cnt = res_cnt + 1'b1;
              mode_nxt = M_IDLE;
              pend_nxt = '0;
            end
          end else begin
            h = stt_pkg::op1(b0);
            if (h.hit) begin
              res[res_cnt] = mk_tok(h.kind, begin_r, p);
              res_cnt = res_cnt + 1'b1;
            end
            mode_nxt = M_IDLE;
            pend_nxt = '0;
            go_idle = 1'b1;
          end
        end else begin
          // pending shift: take the assign form when '=' follows
          mode_nxt = M_IDLE;
          pend_nxt = '0;
          if (c == "=") begin
            res[res_cnt] = mk_tok(stt_pkg::KIND_OP0 + 7'((b0 == "<") ?
                                  stt_pkg::OP_SHL_EQ : stt_pkg::OP_SHR_EQ), begin_r, p + 1'b1);
            res_cnt = res_cnt + 1'b1;
          end else begin
            res[res_cnt] = mk_tok(stt_pkg::KIND_OP0 + 7'((b0 == "<") ?
                                  stt_pkg::OP_SHL : stt_pkg::OP_SHR), begin_r, p);
            res_cnt = res_cnt + 1'b1;
            go_idle = 1'b1;
          end
        end
      end
      M_LSTART: begin
        tflag_nxt = 1'b0;
        if (c == stt_pkg::CH_NL) begin
          mode_nxt = M_IDLE;
        end else begin
          if (c == "/") begin
            tflag_nxt  = 1'b1;
            begin_nxt  = p + 1'b1;
            lastns_nxt = p + 1'b1;
          end
          mode_nxt = M_LBODY;
        end
      end
      M_LBODY: begin
        if (c == stt_pkg::CH_NL) begin
          if (tflag_r) begin
            res[res_cnt] = mk_tok(stt_pkg::KIND_TCOMMENT, begin_r, lastns_r);
            res_cnt = res_cnt + 1'b1;
          end
          tflag_nxt = 1'b0;
          mode_nxt  = M_IDLE;
        end else if (tflag_r && !stt_pkg::is_ws(c)) begin
          lastns_nxt = p + 1'b1;
        end
      end
      M_BSTART: begin
        tflag_nxt = (c == "*");
        star_nxt  = (c == "*");
        mode_nxt  = M_BBODY;
      end
      M_BBODY: begin
        if (star_r && c == "/") begin
          body = begin_r + POS_BITS'(2) + POS_BITS'(tflag_r);
          if (tflag_r && p != body) begin
            res[res_cnt] = mk_tok(stt_pkg::KIND_TCOMMENT, body, p - 1'b1);
            res_cnt = res_cnt + 1'b1;
          end
          tflag_nxt = 1'b0;
          star_nxt  = 1'b0;
          mode_nxt  = M_IDLE;
        end else begin
          star_nxt = (c == "*");
        end
      end
      default: mode_nxt = M_IDLE;
    endcase

    if (go_idle && !stt_pkg::is_ws(c)) begin
      if (stt_pkg::is_letter(c)) begin
        mode_nxt  = M_WORD;
        begin_nxt = p;
        buf_we    = 1'b1;
        buf_widx  = '0;
        fill_nxt  = FILL_W'(1);
      end else begin
        h = stt_pkg::op1(c);
        if (stt_pkg::op1_longer(c)) begin
          begin_nxt = p;
          mode_nxt  = M_OP;
          pend_nxt  = {8'd0, c};
        end else if (h.hit) begin
          begin_nxt = p;
          res[res_cnt] = mk_tok(h.kind, p, p + 1'b1);
          res_cnt = res_cnt + 1'b1;
        end
      end
    end

    // Flush what the final byte leaves open, then clear
    if (in_data.end_of_text) begin
      head_nxt = head;
      for (int j = 0; j < stt_pkg::KW_CHARS; j++) begin
        if (buf_we && buf_widx == IDX_W'(j)) begin
          head_nxt[8*j +: 8] = c;
        end
      end
      case (mode_nxt)
        M_WORD: begin
          res[res_cnt] = mk_tok(stt_pkg::kw_kind(head_nxt, 6'(fill_nxt)), begin_nxt, p + 1'b1);
          res_cnt = res_cnt + 1'b1;
        end
        M_OP: begin
          h = (pend_nxt[15:8] != 8'd0) ? stt_pkg::op2(pend_nxt) : stt_pkg::op1(pend_nxt[7:0]);
          if (h.hit) begin
            res[res_cnt] = mk_tok(h.kind, begin_nxt, p + 1'b1);
            res_cnt = res_cnt + 1'b1;
          end
        end
        M_LBODY: begin
          if (tflag_nxt) begin
            res[res_cnt] = mk_tok(stt_pkg::KIND_TCOMMENT, begin_nxt, lastns_nxt);
            res_cnt = res_cnt + 1'b1;
          end
        end
        M_BSTART, M_BBODY: begin
          res[res_cnt] = mk_tok(stt_pkg::KIND_UNTERM, begin_nxt, p + 1'b1);
          res_cnt = res_cnt + 1'b1;
        end
        default: ;
      endcase
      mode_nxt   = M_IDLE;
      pos_nxt    = '0;
      begin_nxt  = '0;
      lastns_nxt = '0;
      fill_nxt   = '0;
      pend_nxt   = '0;
      tflag_nxt  = 1'b0;
      star_nxt   = 1'b0;
    end else begin
      head_nxt = head;
      pos_nxt  = p + 1'b1;
    end

    if (res_cnt != 2'd0) begin
      res[res_cnt - 1'b1].last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      begin_r  <= '0;
      lastns_r <= '0;
      fill_r   <= '0;
      pend_r   <= '0;
      tflag_r  <= 1'b0;
      star_r   <= 1'b0;
    end else if (in_fire) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      begin_r  <= begin_nxt;
      lastns_r <= lastns_nxt;
      fill_r   <= fill_nxt;
      pend_r   <= pend_nxt;
      tflag_r  <= tflag_nxt;
      star_r   <= star_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && buf_we) begin
      buf_r[buf_widx] <= buf_wdata;
    end
  end

  // Result queue: push up to three beats, pop one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (in_fire) begin
        wr_r <= wr_r + res_cnt;
      end
      if (out_fire) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (in_fire ? 3'(res_cnt) : 3'd0) - (out_fire ? 3'd1 : 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < res_cnt) begin
          q_r[wr_r + 2'(i)] <= res[i];
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("result queue overfilled");

  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.end_of_text) |=> (pos_r == '0 && mode_r == M_IDLE))
    else $error("scanner not cleared after final byte");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.token_kind <= stt_pkg::KIND_UNTERM))
    else $error("token kind out of range");

  a_word_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_WORD) |-> (fill_r != '0)) else $error("word open with empty buffer");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_data.end_of_text) |=> (pos_r == $past(pos_r) + 1'b1))
    else $error("byte position did not advance");
`endif

endmodule

[bench/tb_top.sv]
// Testbench for source_text_tokenizer_unit: random and directed source text, scoreboarded tokens.
// Depends on stt_pkg for the beat types; the expected tokens come from a predictor held here.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {SC_IDLE, SC_WORD, SC_OP, SC_LSTART, SC_LBODY, SC_BSTART, SC_BBODY} scan_t;

  class token_scoreboard;
    string op_names [49] = '{
      "&&", "&=", "&", "==", "=", "||", "|=", "|", "^=", "^",
      ",", ":", "::", ";", "/=", "/", ".*", ".~", ".", ">",
      ">=", "-=", "--", "-", "%", "%=", "!=", "!", "+=", "++",
      "+", "?", "<<=", "<<", ">>=", ">>", "*", "~", "*=", "#",
      "##", "$", "@", "{", "}", "(", ")", "[", "]"};
    string kw_names [22] = '{
      "for", "in", "where", "while", "do", "namespace", "var", "mut",
      "match", "enum", "struct", "use", "break", "trait", "continue",
      "extern", "module", "impl", "public", "protected", "private",
      {"reinterpret", "_cast"}};
    scan_t       mode;
    logic [23:0] pos, tok_begin, last_ns;
    string       word, pend;
    int          fill;
    bit          tflag, pstar;
    stt_pkg::stt_out_t step_tokens [$];
    stt_pkg::stt_out_t pending_tokens [$];
    int          errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      mode = SC_IDLE; pos = '0; tok_begin = '0; last_ns = '0;
      word = ""; pend = ""; fill = 0; tflag = 0; pstar = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    function string chr(byte unsigned c);
      string s;
      s = " ";
      s.putc(0, c);
      return s;
    endfunction

    function int op_index(string s);
      foreach (op_names[i]) if (op_names[i] == s) return i;
      return -1;
    endfunction

    function bit op_starts(string s, bit longer);
      int l;
      foreach (op_names[i]) begin
        l = op_names[i].len();
        if (l < s.len() || (longer && l == s.len())) continue;
        if (op_names[i].substr(0, s.len() - 1) == s) return 1;
      end
      return 0;
    endfunction

    function void add(int kind, logic [23:0] start, logic [23:0] stop);
      stt_pkg::stt_out_t t;
      logic [23:0] d;
      if (step_tokens.size() >= 3) return;
      d = stop - start;
      t.token_kind   = 7'(kind);
      t.token_start  = start;
      t.token_length = (d > 24'd65535) ? 16'hFFFF : d[15:0];
      t.last_of_run  = 1'b0;
      step_tokens.push_back(t);
    endfunction

    function void add_word(logic [23:0] stop);
      int kind;
      kind = 0;
      if (fill <= 16)
        foreach (kw_names[i]) if (kind == 0 && kw_names[i] == word) kind = i + 1;
      add(kind, tok_begin, stop);
    endfunction

    function bit is_ws(byte unsigned c);
      return c == " " || c == "\t" || c == "\n" || c == "\r";
    endfunction

    function bit is_letter(byte unsigned c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function void scan(byte unsigned c, logic [23:0] p);
      string b;
      int k;
      logic [23:0] body;
      case (mode)
        SC_WORD: begin
          if (is_letter(c) || (c >= "0" && c <= "9")) begin
            if (fill < 16) begin
              word = {word, chr(c)};
              fill++;
            end else fill = 17;
            return;
          end
          add_word(p);
          mode = SC_IDLE;
        end
        SC_OP: begin
          if (pend == "/" && (c == "/" || c == "*")) begin
            mode = (c == "/") ? SC_LSTART : SC_BSTART;
            pend = "";
            return;
          end
          // a zero byte extends nothing
          if (c != 0) begin
            b = {pend, chr(c)};
            if (op_starts(b, 0)) begin
              if (pend.len() == 1 && op_starts(b, 1)) pend = b;
              else begin
                k = op_index(b);
                if (k >= 0) add(int'(stt_pkg::KIND_OP0) + k, tok_begin, p + 24'd1);
                mode = SC_IDLE;
                pend = "";
              end
              return;
            end
          end
          k = op_index(pend);
          if (k >= 0) add(int'(stt_pkg::KIND_OP0) + k, tok_begin, p);
          mode = SC_IDLE;
          pend = "";
        end
        SC_LSTART: begin
          tflag = 0;
          if (c == "\n") begin
            mode = SC_IDLE;
            return;
          end
          if (c == "/") begin
            tflag = 1;
            tok_begin = p + 24'd1;
            last_ns = tok_begin;
          end
          mode = SC_LBODY;
          return;
        end
        SC_LBODY: begin
          if (c == "\n") begin
            if (tflag) add(stt_pkg::KIND_TCOMMENT, tok_begin, last_ns);
            tflag = 0;
            mode = SC_IDLE;
          end else if (tflag && !is_ws(c)) last_ns = p + 24'd1;
          return;
        end
        SC_BSTART: begin
          tflag = (c == "*");
          pstar = tflag;
          mode = SC_BBODY;
          return;
        end
        SC_BBODY: begin
          if (pstar && c == "/") begin
            body = tok_begin + 24'd2 + 24'(tflag);
            if (tflag && p != body) add(stt_pkg::KIND_TCOMMENT, body, p - 24'd1);
            tflag = 0;
            pstar = 0;
            mode = SC_IDLE;
          end else pstar = (c == "*");
          return;
        end
        default: ;
      endcase
      if (is_ws(c) || c == 0) return;
      if (is_letter(c)) begin
        mode = SC_WORD;
        tok_begin = p;
        word = chr(c);
        fill = 1;
        return;
      end
      b = chr(c);
      if (op_starts(b, 0)) begin
        tok_begin = p;
        if (op_starts(b, 1)) begin
          mode = SC_OP;
          pend = b;
        end else begin
          k = op_index(b);
          if (k >= 0) add(int'(stt_pkg::KIND_OP0) + k, p, p + 24'd1);
        end
      end
    endfunction

    function void note_byte(stt_pkg::stt_in_t beat);
      int k;
      step_tokens.delete();
      scan(beat.char_code, pos);
      if (beat.end_of_text) begin
        case (mode)
          SC_WORD: add_word(pos + 24'd1);
          SC_OP: begin
            k = op_index(pend);
            if (k >= 0) add(int'(stt_pkg::KIND_OP0) + k, tok_begin, pos + 24'd1);
          end
          SC_LBODY: if (tflag) add(stt_pkg::KIND_TCOMMENT, tok_begin, last_ns);
          SC_BSTART, SC_BBODY: add(stt_pkg::KIND_UNTERM, tok_begin, pos + 24'd1);
          default: ;
        endcase
        clear();
      end else pos = pos + 24'd1;
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
      foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
    endfunction

    task check_token(stt_pkg::stt_out_t got);
      stt_pkg::stt_out_t want;
      if (pending_tokens.size() == 0) begin
        report($sformatf("unexpected token kind %0d start %0d", got.token_kind, got.token_start));
        return;
      end
      want = pending_tokens.pop_front();
      if (got.token_kind !== want.token_kind)
        report($sformatf("kind %0d, want %0d", got.token_kind, want.token_kind));
      if (got.token_start !== want.token_start)
        report($sformatf("start %0d, want %0d", got.token_start, want.token_start));
      if (got.token_length !== want.token_length)
        report($sformatf("length %0d, want %0d", got.token_length, want.token_length));
      if (got.last_of_run !== want.last_of_run)
        report($sformatf("last_of_run %0b, want %0b", got.last_of_run, want.last_of_run));
    endtask
  endclass

  logic     clk, rst_n;
  logic     in_valid, in_ready, out_valid, out_ready;
  stt_pkg::stt_in_t  in_data;
  stt_pkg::stt_out_t out_data;

  token_scoreboard sb;
  int  send_idle, recv_idle, hold_off, cycles;

  source_text_tokenizer_unit dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off when asked
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_token(out_data);
  end

  task automatic send_byte(byte unsigned c, bit eot);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.char_code   <= c;
    in_data.end_of_text <= eot;
    do @(negedge clk); while (!in_ready);
    sb.note_byte(in_data);
    @(posedge clk);
  endtask

  task automatic send_text(string s, bit eot);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eot && (i == s.len() - 1));
  endtask

  function automatic string rand_chars(int n, string pool);
    string s;
    int k;
    s = "";
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(pool.len() - 1);
      s = {s, pool.substr(k, k)};
    end
    return s;
  endfunction

  // one well-formed piece of source text, or noise
  function automatic string fragment();
    string alpha, alnum, body;
    alpha = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    alnum = {alpha, "0123456789"};
    body  = "ab* /x\t_!*";
    case ($urandom_range(13))
      0, 1: return sb.kw_names[$urandom_range(21)];
      2, 3: return {rand_chars(1, alpha), rand_chars($urandom_range(0, 19), alnum)};
      4, 5, 6: return sb.op_names[$urandom_range(48)];
      7: return rand_chars($urandom_range(1, 3), " \t\n\r");
      8: return rand_chars($urandom_range(1, 3), "0123456789");
      9: return {"///", rand_chars($urandom_range(0, 6), body), "\n"};
      10: return {"//", rand_chars($urandom_range(0, 5), body), "\n"};
      11: return {"/**", rand_chars($urandom_range(0, 6), body), "*/"};
      12: return {"/*", rand_chars($urandom_range(0, 6), body), "*/"};
      default: return sb.chr(8'($urandom_range(255)));
    endcase
  endfunction

  task automatic random_phase(int nbytes);
    string s;
    int sent;
    sent = 0;
    while (sent < nbytes) begin
      s = "";
      repeat ($urandom_range(1, 8)) s = {s, fragment(), (($urandom_range(2) == 0) ? " " : "")};
      if ($urandom_range(9) == 0) s = {s, "/*x"};
      if ($urandom_range(9) == 0) s = {s, sb.chr(8'h00)};
      send_text(s, 1);
      // a zero byte is lost in a string; send some raw
      if ($urandom_range(7) == 0) send_byte(8'h00, $urandom_range(1));
      sent += s.len() + 1;
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    hold_off = 0;
    send_idle = 0;
    recv_idle = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text({"for x_9 ", "reinterpret", "_cast abcdefghijklmnopq"}, 1);
    send_text("<<= < a>>= ::/// hi \n", 0);
    send_text("/**q*/ /**/ /** */ & ", 0);
    send_text("/* open", 1);
    send_byte(8'hFF, 0);
    send_text("///", 1);

    send_idle = 37; recv_idle = 84;
    random_phase(135);
    send_idle = 84; recv_idle = 37;
    random_phase(135);
    send_idle = 0; recv_idle = 0;
    hold_off = 400;
    random_phase(135);
    in_valid <= 1'b0;

    while (sb.pending_tokens.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
